// ===== rtl/rop_pkg.sv =====
// ----------------------------------------------------------------------------
// rop_pkg
// Shared types and constants of the rectangle placement table: command codes,
// fixed field widths and the control and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rop_pkg;

  localparam int ID_W     = 6;
  localparam int MARGIN_W = 12;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_TRY   = 2'd1,
    CMD_SET   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming item
    logic setup;  // form the grown bounds
    logic scan;   // read one table entry and test the previous one
    logic sweep;  // write one table entry as invalid
    logic done;   // present the result and store the rectangle if placed
  } rop_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic sweep_last;
  } rop_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rect_overlap_placement_table.sv =====
// ----------------------------------------------------------------------------
// rect_overlap_placement_table
// Check and try-place scan the table before the result strobe, one table entry
// read and tested per cycle. Clear sweeps the table, one entry invalidated per
// cycle. One item at a time: busy_o falls with the strobe, so the next item can
// be taken while the strobe is shown.
// After reset a clearing pass runs with busy_o high.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

// The block holds a table of rectangles, one slot per node id. A check or
// try-place item grows the proposed rectangle by the margin register on every
// side and compares it against every valid slot except its own, keeping the
// lowest overlapping id. Touching edges do not count as overlap. Try-place
// stores the rectangle only when nothing overlaps; set stores it directly;
// clear invalidates every slot. Ids at or above MAX_NODES are never stored.
//
// The controller sequences the work and the datapath holds the table memory.
// Each stored word carries a valid bit, so clearing is a sweep that writes
// invalid words through the single write port, both after reset and on a
// clear item. Far edges are stored pre-added so that the scan needs only
// compares.
//
// The margin is written through the configuration channel, which is always
// ready. It should only be written while the block is idle.

module rect_overlap_placement_table
  import rop_pkg::*;
#(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Item channel.
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic [ID_W-1:0]              node_id_i,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire logic [COORD_BITS-2:0]        rect_width_i,
  input  wire logic [COORD_BITS-2:0]        rect_height_i,
  // Result channel.
  output logic                              done_o,
  output logic                              placed_o,
  output logic                              conflict_o,
  output logic [ID_W-1:0]                   conflict_id_o,
  // Configuration channel for the margin register.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [MARGIN_W-1:0]          cfg_data_i
);

  rop_ctrl_t ctrl;
  rop_stat_t stat;
  logic      cfg_we;

  // The margin register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  rop_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o)
  );

  rop_datapath #(
    .MAX_NODES  (MAX_NODES),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .node_id_i     (node_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .done_o        (done_o),
    .placed_o      (placed_o),
    .conflict_o    (conflict_o),
    .conflict_id_o (conflict_id_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rop_ctrl.sv =====
// ----------------------------------------------------------------------------
// rop_ctrl
// Sequencer of the placement table: reset sweep, command dispatch, setup, table
// scan, clear sweep and result phase.
// ----------------------------------------------------------------------------
`default_nettype none

module rop_ctrl
  import rop_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic [1:0] command_i,
  input  wire rop_stat_t stat_i,
  output rop_ctrl_t      ctrl_o,
  output logic           busy_o
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SETUP = 6'b000100,
    S_SCAN  = 6'b001000,
    S_CLEAR = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd;

  assign cmd = cmd_e'(command_i);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_INIT: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.load = 1'b1;
          unique case (cmd) inside
            CMD_CHECK, CMD_TRY: state_d = S_SETUP;
            CMD_SET:            state_d = S_DONE;
            default:            state_d = S_CLEAR;
          endcase
        end
      end
      S_SETUP: begin
        ctrl_o.setup = 1'b1;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        ctrl_o.done = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rop_datapath.sv =====
// ----------------------------------------------------------------------------
// rop_datapath
// Item registers, margin register, rectangle table memory, scan counter,
// overlap comparators and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rop_datapath
  import rop_pkg::*;
#(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rop_ctrl_t                    ctrl_i,
  output rop_stat_t                         stat_o,
  input  wire logic                         cfg_valid_i,
  input  wire logic [MARGIN_W-1:0]          cfg_data_i,
  input  wire logic [1:0]                   command_i,
  input  wire logic [ID_W-1:0]              node_id_i,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire logic [COORD_BITS-2:0]        rect_width_i,
  input  wire logic [COORD_BITS-2:0]        rect_height_i,
  output logic                              done_o,
  output logic                              placed_o,
  output logic                              conflict_o,
  output logic [ID_W-1:0]                   conflict_id_o
);

  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int IDW    = (IDX_W > ID_W) ? IDX_W : ID_W;
  localparam int EXT    = ((COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W) + 3;
  localparam int END_W  = COORD_BITS + 1;
  localparam int WORD_W = 1 + 2 * COORD_BITS + 2 * END_W;

  // Item registers. The far edges are stored as x + w and y + h.
  cmd_e                          cmd_q;
  logic [ID_W-1:0]               id_q;
  logic signed [COORD_BITS-1:0]  px_q, py_q;
  logic signed [END_W-1:0]       pxe_q, pye_q;
  logic [MARGIN_W-1:0]           margin_q;
  logic signed [EXT-1:0]         x1_q, x2_q, y1_q, y2_q;
  logic signed [EXT-1:0]         m_ext;

  logic [CNT_W-1:0]              cnt_q;
  logic                          chk_vld_q;
  logic [IDX_W-1:0]              chk_idx_q;
  logic [WORD_W-1:0]             rd_q;
  logic [WORD_W-1:0]             mem_q [MAX_NODES];
  logic                          found_q;
  logic [ID_W-1:0]               cid_q;

  logic                          rd_en, wr_en, id_ok, placed, hit;
  logic [IDX_W-1:0]              wr_addr;
  logic [WORD_W-1:0]             wr_data;
  logic [IDW-1:0]                id_ext;

  logic                          ent_vld;
  logic signed [EXT-1:0]         ox, oy, ox2, oy2;

  assign m_ext  = $signed(EXT'(margin_q));
  assign id_ext = IDW'(id_q);
  assign id_ok  = 32'(id_q) < MAX_NODES;
  assign placed = id_ok && ((cmd_q == CMD_SET) || ((cmd_q == CMD_TRY) && !found_q));

  assign stat_o.scan_last  = 32'(cnt_q) == MAX_NODES;
  assign stat_o.sweep_last = 32'(cnt_q) == (MAX_NODES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (cfg_valid_i) begin
      margin_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= node_id_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pxe_q <= END_W'(pos_x_i) + $signed({2'b00, rect_width_i});
      pye_q <= END_W'(pos_y_i) + $signed({2'b00, rect_height_i});
    end
    if (ctrl_i.setup) begin
      x1_q <= EXT'(px_q) - m_ext;
      y1_q <= EXT'(py_q) - m_ext;
      x2_q <= EXT'(pxe_q) + m_ext;
      y2_q <= EXT'(pye_q) + m_ext;
    end
    chk_idx_q <= cnt_q[IDX_W-1:0];
  end

  // Table memory, one write and one registered read port.
  assign rd_en   = ctrl_i.scan && (32'(cnt_q) < MAX_NODES);
  assign wr_en   = ctrl_i.sweep || (ctrl_i.done && placed);
  assign wr_addr = ctrl_i.sweep ? cnt_q[IDX_W-1:0] : id_ext[IDX_W-1:0];
  assign wr_data = ctrl_i.sweep ? '0 : {1'b1, px_q, py_q, pxe_q, pye_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[cnt_q[IDX_W-1:0]];
    end
  end

  assign ent_vld = rd_q[WORD_W-1];
  assign ox      = EXT'($signed(rd_q[WORD_W-2 -: COORD_BITS]));
  assign oy      = EXT'($signed(rd_q[WORD_W-2-COORD_BITS -: COORD_BITS]));
  assign ox2     = EXT'($signed(rd_q[2*END_W-1 -: END_W]));
  assign oy2     = EXT'($signed(rd_q[END_W-1:0]));

  assign hit = chk_vld_q && ent_vld && !found_q && (IDW'(chk_idx_q) != id_ext) &&
               (x1_q < ox2) && (x2_q > ox) && (y1_q < oy2) && (y2_q > oy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      cid_q     <= '0;
    end else begin
      chk_vld_q <= rd_en;
      if (ctrl_i.load || ctrl_i.setup) begin
        cnt_q <= '0;
      end else if (ctrl_i.scan || ctrl_i.sweep) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.load) begin
        found_q <= 1'b0;
        cid_q   <= '0;
      end else if (hit) begin
        found_q <= 1'b1;
        cid_q   <= ID_W'(chk_idx_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctrl_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.done) begin
      placed_o      <= placed;
      conflict_o    <= found_q;
      conflict_id_o <= cid_q;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_rect_overlap_placement_table.sv =====
// ----------------------------------------------------------------------------
// tb_rect_overlap_placement_table
// Self-checking regression of the rectangle placement table. Directed items
// cover the overlap rules, touching edges, the own-slot skip, zero-size and
// extreme rectangles, clear and the margin limits. Random traffic follows:
// mostly clustered and edge-hugging rectangles, plus raw noise. Every item
// is predicted in the bench and each strobed result is compared with the
// oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rect_overlap_placement_table;
  import rop_pkg::*;

  localparam int NODES      = 64;
  localparam int CW         = 16;
  localparam int MARGIN_MAX = (1 << MARGIN_W) - 1;

  // One input item as the block sees it on its ports.
  typedef struct {
    cmd_e                  command;
    logic [ID_W-1:0]       node_id;
    logic signed [CW-1:0]  pos_x;
    logic signed [CW-1:0]  pos_y;
    logic [CW-2:0]         width;
    logic [CW-2:0]         height;
  } request_t;

  // One result item.
  typedef struct {
    logic            placed;
    logic            conflict;
    logic [ID_W-1:0] conflict_id;
  } outcome_t;

  // A stored rectangle, widened to int so that far edges never overflow.
  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            command_i;
  logic [ID_W-1:0]       node_id_i;
  logic signed [CW-1:0]  pos_x_i;
  logic signed [CW-1:0]  pos_y_i;
  logic [CW-2:0]         rect_width_i;
  logic [CW-2:0]         rect_height_i;
  logic                  done_o;
  logic                  placed_o;
  logic                  conflict_o;
  logic [ID_W-1:0]       conflict_id_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [MARGIN_W-1:0]   cfg_data_i;

  // Shadow copy of the table and the margin register, kept in item order.
  bit                    slot_valid [NODES];
  box_t                  slot_box   [NODES];
  logic [MARGIN_W-1:0]   margin_setting;

  outcome_t              expected_outcomes [$];
  int                    error_count;
  int                    sender_idle_pct;

  rect_overlap_placement_table #(
    .MAX_NODES  (NODES),
    .COORD_BITS (CW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .node_id_i     (node_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .done_o        (done_o),
    .placed_o      (placed_o),
    .conflict_o    (conflict_o),
    .conflict_id_o (conflict_id_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Works out the result of one item and applies its effect on the shadow
  // table. The proposal is grown by the margin on every side, and only a
  // strict overlap counts, so rectangles that share an edge pass. The scan
  // runs from slot 0 upward and keeps only the first hit, which yields the
  // lowest conflicting id. The own slot is never tested against itself.
  // With 6-bit ids and 64 slots, every id names a real slot.
  function automatic outcome_t predict_placement(input request_t req);
    outcome_t res;
    box_t     b;
    int       m;
    int       x1;
    int       y1;
    int       x2;
    int       y2;
    res.placed      = 1'b0;
    res.conflict    = 1'b0;
    res.conflict_id = '0;
    b.x = int'(req.pos_x);
    b.y = int'(req.pos_y);
    b.w = int'(req.width);
    b.h = int'(req.height);
    m   = int'(margin_setting);
    case (req.command)
      CMD_CLEAR: begin
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      end
      CMD_SET: begin
        slot_box[req.node_id]   = b;
        slot_valid[req.node_id] = 1'b1;
        res.placed              = 1'b1;
      end
      default: begin
        x1 = b.x - m;
        y1 = b.y - m;
        x2 = b.x + b.w + m;
        y2 = b.y + b.h + m;
        for (int i = 0; i < NODES; i++) begin
          if (!res.conflict && slot_valid[i] && i != int'(req.node_id) &&
              x1 < slot_box[i].x + slot_box[i].w && x2 > slot_box[i].x &&
              y1 < slot_box[i].y + slot_box[i].h && y2 > slot_box[i].y) begin
            res.conflict    = 1'b1;
            res.conflict_id = i[ID_W-1:0];
          end
        end
        if (req.command == CMD_TRY && !res.conflict) begin
          slot_box[req.node_id]   = b;
          slot_valid[req.node_id] = 1'b1;
          res.placed              = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic request_t make_request(input cmd_e c, input int id, input int x,
                                            input int y, input int w, input int h);
    request_t req;
    req.command = c;
    req.node_id = id[ID_W-1:0];
    req.pos_x   = x[CW-1:0];
    req.pos_y   = y[CW-1:0];
    req.width   = w[CW-2:0];
    req.height  = h[CW-2:0];
    return req;
  endfunction

  // Random item. One in ten is raw noise over the full field ranges. The
  // rest are well-formed: small rectangles in a crowded window so that the
  // table fills up and overlaps are common, and half of the time, when the
  // chosen anchor slot is occupied, a rectangle placed against one side of
  // that slot, exactly touching after growth or one unit in or out.
  function automatic request_t random_request();
    request_t req;
    int       pick;
    int       anchor;
    int       nudge;
    int       m;
    int       px;
    int       py;
    int       w;
    int       h;
    m    = int'(margin_setting);
    pick = $urandom_range(99);
    req.node_id = ID_W'($urandom_range(NODES - 1));
    if (pick < 10) begin
      req.command = cmd_e'($urandom_range(3));
      req.pos_x   = CW'($urandom);
      req.pos_y   = CW'($urandom);
      req.width   = (CW-1)'($urandom);
      req.height  = (CW-1)'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        req.command = CMD_CHECK;
      end else if (pick < 75) begin
        req.command = CMD_TRY;
      end else if (pick < 97) begin
        req.command = CMD_SET;
      end else begin
        req.command = CMD_CLEAR;
      end
      w  = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 127));
      h  = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 127));
      px = int'($urandom_range(511)) - 256;
      py = int'($urandom_range(511)) - 256;
      anchor = int'($urandom_range(NODES - 1));
      if (slot_valid[anchor] && $urandom_range(1) == 1) begin
        nudge = int'($urandom_range(2)) - 1;
        px = slot_box[anchor].x + int'($urandom_range(31)) - 16;
        py = slot_box[anchor].y + int'($urandom_range(31)) - 16;
        case ($urandom_range(3))
          0:       px = slot_box[anchor].x + slot_box[anchor].w + m + nudge;
          1:       px = slot_box[anchor].x - w - m + nudge;
          2:       py = slot_box[anchor].y + slot_box[anchor].h + m + nudge;
          default: py = slot_box[anchor].y - h - m + nudge;
        endcase
      end
      req.pos_x  = px[CW-1:0];
      req.pos_y  = py[CW-1:0];
      req.width  = w[CW-2:0];
      req.height = h[CW-2:0];
    end
    return req;
  endfunction

  // Sends one item. The sender may first idle at random with start low; start
  // then stays high until the block takes the item at an edge where busy is low.
  // Start is left high on return, and the next caller either drives a new
  // item or lowers it at the following falling edge.
  task automatic send_request(input request_t req);
    outcome_t expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= req.command;
    node_id_i     <= req.node_id;
    pos_x_i       <= req.pos_x;
    pos_y_i       <= req.pos_y;
    rect_width_i  <= req.width;
    rect_height_i <= req.height;
    do @(posedge clk_i); while (busy_o);
    expected          = predict_placement(req);
    expected_outcomes = {expected_outcomes, expected};
  endtask

  // Stops sending and waits until every result is in and the block reports
  // itself free again; this also covers the clearing pass after reset.
  task automatic wait_until_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    wait_until_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    margin_setting = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Basic overlap rules with no margin: empty table, own-slot skip, edges
  // that only touch, lowest id among several hits, set without a check, and
  // zero-size rectangles inside a slot and on its corner.
  task automatic test_overlap_rules();
    send_request(make_request(CMD_CHECK, 0, 0, 0, 16, 16));
    send_request(make_request(CMD_TRY, 5, 0, 0, 16, 16));
    send_request(make_request(CMD_CHECK, 5, 0, 0, 16, 16));
    send_request(make_request(CMD_TRY, 7, 16, 0, 16, 16));
    send_request(make_request(CMD_TRY, 8, 0, -16, 16, 16));
    send_request(make_request(CMD_TRY, 2, 15, 0, 2, 16));
    send_request(make_request(CMD_CHECK, 5, 15, 0, 2, 16));
    send_request(make_request(CMD_SET, 1, 15, 0, 2, 16));
    send_request(make_request(CMD_CHECK, 30, 8, 8, 0, 0));
    send_request(make_request(CMD_CHECK, 30, 0, 0, 0, 0));
    send_request(make_request(CMD_TRY, 31, 32, 16, 0, 0));
  endtask

  // Most negative and most positive corners with the widest rectangles.
  task automatic test_coordinate_extremes();
    send_request(make_request(CMD_SET, 63, -32768, -32768, 32767, 32767));
    send_request(make_request(CMD_SET, 0, 32767, 32767, 32767, 32767));
    send_request(make_request(CMD_CHECK, 62, 32767, -32768, 0, 32767));
    send_request(make_request(CMD_TRY, 62, -32768, 32767, 32767, 0));
    send_request(make_request(CMD_CHECK, 63, -1, -1, 32767, 32767));
  endtask

  // Clear with every payload bit set, then a probe that would have hit.
  task automatic test_clear_all();
    send_request(make_request(CMD_CLEAR, 63, -1, -1, 32767, 32767));
    send_request(make_request(CMD_CHECK, 0, 0, 0, 16, 16));
  endtask

  // With the largest margin, a proposal exactly one margin away from a slot
  // just touches it and one unit closer overlaps it. A margin of one shows
  // the same boundary on the near side.
  task automatic test_margin_growth();
    write_margin(MARGIN_W'(MARGIN_MAX));
    send_request(make_request(CMD_TRY, 1, 0, 0, 16, 16));
    send_request(make_request(CMD_TRY, 2, 16 + MARGIN_MAX, 0, 16, 16));
    send_request(make_request(CMD_CHECK, 3, 15 + MARGIN_MAX, 0, 16, 16));
    send_request(make_request(CMD_CHECK, 2, 15 + MARGIN_MAX, 0, 16, 16));
    write_margin(MARGIN_W'(1));
    send_request(make_request(CMD_CHECK, 3, 17, 0, 16, 16));
    send_request(make_request(CMD_CLEAR, 0, 0, 0, 0, 0));
  endtask

  // Random traffic under one sender idle rate. The margin moves between the
  // extremes, one and random values every fifty items, each time once the
  // block has drained.
  task automatic test_random_traffic(input int idle_pct, input int count);
    logic [MARGIN_W-1:0] next_margin;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(4))
          0:       next_margin = '0;
          1:       next_margin = MARGIN_W'(MARGIN_MAX);
          2:       next_margin = MARGIN_W'(1);
          3:       next_margin = MARGIN_W'($urandom_range(2, 40));
          default: next_margin = MARGIN_W'($urandom_range(MARGIN_MAX));
        endcase
        write_margin(next_margin);
      end
      send_request(random_request());
    end
  endtask

  // Each strobed result is taken at the edge that ends its cycle and is
  // compared with the oldest prediction, one field at a time.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no item outstanding: placed %0b conflict %0b id %0d",
               placed_o, conflict_o, conflict_id_o);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (placed_o !== want.placed) begin
          $error("placed: expected %0b, actual %0b", want.placed, placed_o);
          error_count++;
        end
        if (conflict_o !== want.conflict) begin
          $error("conflict: expected %0b, actual %0b", want.conflict, conflict_o);
          error_count++;
        end
        if (conflict_id_o !== want.conflict_id) begin
          $error("conflict_id: expected %0d, actual %0d", want.conflict_id,
                 conflict_id_o);
          error_count++;
        end
      end
    end
  end

  // A run that has not finished by the watchdog time ends as a failure.
  initial begin
    #2_000_000;
    $display("rect_overlap_placement_table regression: fail");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    command_i       = CMD_CHECK;
    node_id_i       = '0;
    pos_x_i         = '0;
    pos_y_i         = '0;
    rect_width_i    = '0;
    rect_height_i   = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    margin_setting  = '0;
    error_count     = 0;
    sender_idle_pct = 16;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_overlap_rules();
    test_coordinate_extremes();
    test_clear_all();
    test_margin_growth();
    test_random_traffic(16, 200);
    test_random_traffic(75, 200);
    test_random_traffic(0, 200);

    // Drain, then leave room for any stray strobe to show up.
    wait_until_idle();
    repeat (80) @(posedge clk_i);
    error_count += expected_outcomes.size();
    if (error_count == 0) begin
      $display("rect_overlap_placement_table regression: pass");
    end else begin
      $display("rect_overlap_placement_table regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
